// ===== hw/rtl/sitda_pkg.sv =====
// ----------------------------------------------------------------------------
// sitda_pkg: shared types and constants
// Controller state, digit cell control group and ASCII codes.
// ----------------------------------------------------------------------------
package sitda_pkg;

  localparam logic [7:0] CHAR_ZERO  = 8'd48;
  localparam logic [7:0] CHAR_MINUS = 8'd45;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CONV,
    S_SIGN,
    S_EMIT
  } sitda_state_t;

  // clear: zero the digit; dabble: add-3 correction then shift a bit in;
  // move: take the lower neighbor's digit (shift the row toward the top)
  typedef struct packed {
    logic clear;
    logic dabble;
    logic move;
  } sitda_cell_ctrl_t;

endpackage

// ===== hw/rtl/sitda_if.sv =====
// ----------------------------------------------------------------------------
// sitda_if: request channels
// Input channel (one signed value) and result channel (one character).
// ----------------------------------------------------------------------------
interface sitda_in_if #(
  parameter int VALUE_BITS = 32
) ();
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface sitda_out_if ();
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       is_last;

  modport source (output valid, output char_code, output is_last, input ready);
  modport sink   (input valid, input char_code, input is_last, output ready);
endinterface

// ===== hw/rtl/sitda_cell.sv =====
// ----------------------------------------------------------------------------
// sitda_cell: one BCD digit cell
// Holds one decimal digit; shift-add-3 step during conversion, plain
// neighbor-to-neighbor move while the digits are read out.
// ----------------------------------------------------------------------------
module sitda_cell (
  input  logic                       clk,
  input  sitda_pkg::sitda_cell_ctrl_t ctrl,
  input  logic                       bit_in,
  input  logic [3:0]                 digit_in,
  output logic [3:0]                 digit_o,
  output logic                       carry_o
);
  import sitda_pkg::*;

  logic [3:0] digit_r;
  logic [3:0] digit_nxt;
  logic [3:0] adj;

  assign adj     = (digit_r >= 4'd5) ? (digit_r + 4'd3) : digit_r;
  assign carry_o = adj[3];
  assign digit_o = digit_r;

  always_comb begin
    digit_nxt = digit_r;
    if (ctrl.clear) begin
      digit_nxt = 4'd0;
    end else if (ctrl.dabble) begin
      digit_nxt = {adj[2:0], bit_in};
    end else if (ctrl.move) begin
      digit_nxt = digit_in;
    end
  end

  always_ff @(posedge clk) begin
    digit_r <= digit_nxt;
  end

endmodule

// ===== hw/rtl/sitda_chain.sv =====
// ----------------------------------------------------------------------------
// sitda_chain: row of digit cells
// Cell 0 is the least significant digit; bits and digits travel upward.
// ----------------------------------------------------------------------------
module sitda_chain #(
  parameter int NDIG = 10
) (
  input  logic                        clk,
  input  sitda_pkg::sitda_cell_ctrl_t ctrl,
  input  logic                        bit_in,
  output logic [3:0]                  top_digit
);
  import sitda_pkg::*;

  logic [3:0] digit [NDIG];
  logic       carry [NDIG];

  for (genvar i = 0; i < NDIG; i++) begin : g_cell
    if (i == 0) begin : g_first
      sitda_cell u_cell (
        .clk      (clk),
        .ctrl     (ctrl),
        .bit_in   (bit_in),
        .digit_in (4'd0),
        .digit_o  (digit[i]),
        .carry_o  (carry[i])
      );
    end else begin : g_next
      sitda_cell u_cell (
        .clk      (clk),
        .ctrl     (ctrl),
        .bit_in   (carry[i-1]),
        .digit_in (digit[i-1]),
        .digit_o  (digit[i]),
        .carry_o  (carry[i])
      );
    end
  end

  // the top cell's carry would be a digit beyond the row; it never occurs
  assign top_digit = digit[NDIG-1];

endmodule

// ===== hw/rtl/signed_int_to_decimal_ascii.sv =====
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii: signed integer to decimal ASCII text
// Converts one two's complement value into its decimal characters.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch takes one signed VALUE_BITS value per request; out_ch returns its
//   text one character per request, most significant first, with a leading
//   '-' for negative values, no leading zeros, and is_last on the final one.
//   The magnitude is formed unsigned, so the most negative value is exact.
// Operation:
//   One value is worked on at a time. After acceptance, the magnitude is
//   shifted MSB first into a row of NDIG BCD cells (shift-add-3), one bit a
//   cycle. Read-out then sends the sign if present and walks the NDIG
//   digits from the top, dropping leading zeros.
// Stall / reset:
//   Characters sit in an output register; while it waits on out_ch.ready the
//   digit row holds, except that leading zeros still drop. The next value is
//   taken as soon as the last character is in that register. Reset
//   (synchronous, rst_n low) returns to idle and empties the output register.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii #(
  parameter int VALUE_BITS = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  sitda_in_if.sink      in_ch,
  sitda_out_if.source   out_ch
);
  import sitda_pkg::*;

  // decimal digits of 2^(VALUE_BITS-1)
  localparam int NDIG = ((VALUE_BITS - 1) * 30103) / 100000 + 1;
  localparam int BCW  = $clog2(VALUE_BITS);
  localparam int RW   = $clog2(NDIG + 1);

  sitda_state_t           state_r, state_nxt;
  logic [VALUE_BITS-1:0]  mag_r;
  logic [VALUE_BITS-1:0]  mag_in;
  logic                   neg_r;
  logic [BCW-1:0]         bit_cnt_r;
  logic [RW-1:0]          rem_r;
  logic                   started_r;
  logic                   out_valid_r;
  logic [7:0]             char_r;
  logic                   last_r;

  sitda_cell_ctrl_t ctrl;
  logic [3:0]       top_d;
  logic             accept;
  logic             slot_free;
  logic             last_dig;
  logic             skip;
  logic             emit;
  logic             sign_emit;

  assign mag_in = in_ch.value[VALUE_BITS-1]
                ? ({VALUE_BITS{1'b0}} - $unsigned(in_ch.value))
                : $unsigned(in_ch.value);

  assign in_ch.ready      = (state_r == S_IDLE);
  assign accept           = in_ch.valid && in_ch.ready;
  assign slot_free        = !out_valid_r || out_ch.ready;
  assign out_ch.valid     = out_valid_r;
  assign out_ch.char_code = char_r;
  assign out_ch.is_last   = last_r;

  sitda_chain #(.NDIG(NDIG)) u_chain (
    .clk       (clk),
    .ctrl      (ctrl),
    .bit_in    (mag_r[VALUE_BITS-1]),
    .top_digit (top_d)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_CONV;
      end
      S_CONV: begin
        if (bit_cnt_r == '0) state_nxt = neg_r ? S_SIGN : S_EMIT;
      end
      S_SIGN: begin
        if (slot_free) state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (emit && last_dig) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs of the controller
  always_comb begin
    last_dig    = (rem_r == RW'(1));
    skip        = 1'b0;
    emit        = 1'b0;
    sign_emit   = 1'b0;
    ctrl.clear  = 1'b0;
    ctrl.dabble = 1'b0;
    ctrl.move   = 1'b0;
    case (state_r)
      S_IDLE: begin
        ctrl.clear = accept;
      end
      S_CONV: begin
        ctrl.dabble = 1'b1;
      end
      S_SIGN: begin
        sign_emit = slot_free;
      end
      S_EMIT: begin
        // drop leading zeros, but always send the units digit
        skip      = !started_r && (top_d == 4'd0) && !last_dig;
        emit      = !skip && slot_free;
        ctrl.move = skip || emit;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      started_r   <= 1'b0;
      bit_cnt_r   <= '0;
      rem_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (emit || sign_emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (accept) begin
        started_r <= 1'b0;
        bit_cnt_r <= BCW'(VALUE_BITS - 1);
        rem_r     <= RW'(NDIG);
      end else begin
        if (state_r == S_CONV) bit_cnt_r <= bit_cnt_r - 1'b1;
        if (ctrl.move)         rem_r     <= rem_r - 1'b1;
        if (emit)              started_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mag_r <= mag_in;
      neg_r <= in_ch.value[VALUE_BITS-1];
    end else if (state_r == S_CONV) begin
      mag_r <= {mag_r[VALUE_BITS-2:0], 1'b0};
    end
    if (sign_emit) begin
      char_r <= CHAR_MINUS;
      last_r <= 1'b0;
    end else if (emit) begin
      char_r <= CHAR_ZERO + {4'd0, top_d};
      last_r <= last_dig;
    end
  end

endmodule

// ===== tb/signed_int_to_decimal_ascii_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_test: self-checking bench for the itoa block
// Drives signed values with random sender gaps and receiver stalls, predicts
// each value's decimal text and checks every character request in order.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_test;
  import sitda_pkg::*;

  localparam int VB = 32;
  localparam int RADIX = 10;
  localparam int NUM_RANDOM = 380;
  localparam int CYCLE_LIMIT = 600000;
  localparam int TAIL_CYCLES = 60;

  class ascii_text_scoreboard #(int VB = 32);
    typedef struct packed {
      logic [7:0] code;
      logic       last;
    } text_char_t;

    text_char_t expected_text[$];
    int         errors;

    function new();
      errors = 0;
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      errors++;
    endtask

    function int pending();
      return expected_text.size();
    endfunction

    // decimal text of one accepted value; magnitude taken unsigned so the
    // most negative value needs no special handling
    function void note_value(logic [VB-1:0] bits);
      logic [VB-1:0] mag;
      logic [7:0]    digits[$];
      text_char_t    ch;
      mag = bits[VB-1] ? (~bits + 1'b1) : bits;
      do begin
        digits.push_front(CHAR_ZERO + 8'(mag % RADIX));
        mag = mag / RADIX;
      end while (mag != 0);
      if (bits[VB-1]) begin
        ch.code = CHAR_MINUS;
        ch.last = 1'b0;
        expected_text.push_back(ch);
      end
      foreach (digits[i]) begin
        ch.code = digits[i];
        ch.last = (i == digits.size() - 1);
        expected_text.push_back(ch);
      end
    endfunction

    task check_char(logic [7:0] code, logic last);
      text_char_t want;
      if (expected_text.size() == 0) begin
        report($sformatf("unexpected char 0x%02h last=%0b", code, last));
        return;
      end
      want = expected_text.pop_front();
      if (code !== want.code)
        report($sformatf("char_code 0x%02h, want 0x%02h", code, want.code));
      if (last !== want.last)
        report($sformatf("is_last %0b, want %0b (char 0x%02h)", last, want.last, want.code));
    endtask

    task check_leftover();
      if (expected_text.size() != 0)
        report($sformatf("%0d chars never arrived", expected_text.size()));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;
  bit   idle_on;
  int   cycle_count = 0;

  ascii_text_scoreboard #(VB) sb;

  sitda_in_if #(.VALUE_BITS(VB)) in_ch ();
  sitda_out_if out_ch ();

  signed_int_to_decimal_ascii #(
    .VALUE_BITS(VB)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always #6 clk = ~clk;

  // requests are taken on the values seen at the edge, before any update
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) sb.note_value(in_ch.value);
      if (out_ch.valid && out_ch.ready) sb.check_char(out_ch.char_code, out_ch.is_last);
    end
  end

  initial begin : sink_proc
    int n;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (idle_on && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 17);
        out_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  // valid is left high on return; a gap in the next call or wait_text_drained lowers it
  task automatic send_value(input logic signed [VB-1:0] v);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 17);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.value <= v;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // one edge first, so the request taken at the last edge is already noted
  task automatic wait_text_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic logic signed [VB-1:0] random_value();
    int                  kind;
    int                  ndig;
    bit                  neg;
    longint              lo;
    longint              hi;
    longint              mag;
    logic signed [63:0]  s;
    kind = $urandom_range(0, 9);
    ndig = $urandom_range(1, 10);
    neg = $urandom_range(0, 1);
    lo = 1;
    for (int i = 1; i < ndig; i++) lo = lo * RADIX;
    hi = lo * RADIX - 1;
    if (hi > 64'sd2147483648) hi = 64'sd2147483648;
    case (kind)
      0, 1, 2, 3: begin
        return $urandom();
      end
      8: begin
        // digit-count boundaries: 10^k and 10^k - 1
        mag = $urandom_range(0, 1) ? lo : lo - 1;
      end
      9: begin
        case ($urandom_range(0, 4))
          0: return 0;
          1: return 1;
          2: return -1;
          3: return {1'b0, {(VB-1){1'b1}}};
          default: return {1'b1, {(VB-1){1'b0}}};
        endcase
      end
      default: begin
        mag = lo + longint'($urandom_range(0, 32'(hi - lo)));
      end
    endcase
    if (!neg && mag > 64'sd2147483647) mag = 64'sd2147483647;
    s = neg ? -mag : mag;
    return s[VB-1:0];
  endfunction

  initial begin : stimulus
    logic signed [VB-1:0] corner_values[] = '{
      32'sh00000000, 32'sh00000001, 32'shFFFFFFFF, 32'sd9, 32'sd10, -32'sd10,
      32'sd99, 32'sd100, 32'sh7FFFFFFF, 32'sh80000000, 32'sh80000001,
      32'sd1000000000, 32'sd999999999, -32'sd1000000000, 32'sd123456789,
      -32'sd987654321, 32'sh55555555, 32'shAAAAAAAA, 32'sd7, -32'sd9,
      -32'sd2147483647, 32'sd1999999999
    };
    sb = new();
    rst_n = 1'b0;
    idle_on = 1'b1;
    in_ch.valid <= 1'b0;
    in_ch.value <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (corner_values[i]) send_value(corner_values[i]);
    wait_text_drained();

    for (int i = 0; i < NUM_RANDOM; i++) begin
      // stretches of no idling inside, none at all near the end
      idle_on = (i < 300) && ((i / 60) % 3 != 2);
      if (i == 150) wait_text_drained();
      send_value(random_value());
    end

    wait_text_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    sb.check_leftover();
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/sitda_pkg.sv
hw/rtl/sitda_if.sv
hw/rtl/sitda_cell.sv
hw/rtl/sitda_chain.sv
hw/rtl/signed_int_to_decimal_ascii.sv
tb/signed_int_to_decimal_ascii_test.sv
